[design/bpe_pkg.sv]
package bpe_pkg;

	// Default build values
	localparam int MAX_POINTS_DEF = 16;
	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed field and format widths
	localparam int OP_W    = 3;
	localparam int PIX_W   = 10;
	localparam int ADDR_W  = 6;
	localparam int COUNT_W = 7;
	localparam int T_W     = 17;
	localparam int T_BITS  = 16;
	localparam int RAD_W   = 4;

	localparam logic [T_W-1:0]   T_ONE          = 17'd65536;
	localparam logic [RAD_W-1:0] HIT_RADIUS_RST = 4'd2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 3'd0,
		OP_MOVE     = 3'd1,
		OP_DELETE   = 3'd2,
		OP_REM_LAST = 3'd3,
		OP_CLEAR    = 3'd4,
		OP_FIND     = 3'd5,
		OP_EVAL     = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_TOO_FEW   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DEL_RD,
		S_DEL_WR,
		S_FIND_RD,
		S_FIND_CMP,
		S_EV_RD,
		S_EV_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PIX_W-1:0]  x_in;
		logic [PIX_W-1:0]  y_in;
		logic [ADDR_W-1:0] index_in;
		logic [T_W-1:0]    t_in;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [PIX_W-1:0]   x_out;
		logic [PIX_W-1:0]   y_out;
		logic [ADDR_W-1:0]  index_out;
		logic [COUNT_W-1:0] count_out;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic              cap;
		logic              pt_we;
		logic              pt_wsel;
		logic [ADDR_W-1:0] pt_waddr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              ev_vld;
		logic              ev_first;
		logic              ev_src_pts;
		logic [ADDR_W-1:0] ev_waddr;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             hit;
		logic [PIX_W-1:0] res_x;
		logic [PIX_W-1:0] res_y;
	} dp_stat_t;

endpackage

[design/bpe_dp.sv]
module bpe_dp #(
	parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpe_pkg::RAD_W-1:0]     cfg_data,
	input  bpe_pkg::in_item_t             item,
	input  bpe_pkg::cmd_t                 cmd,
	output bpe_pkg::dp_stat_t             st
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int W  = COORD_BITS + FRAC_BITS;
	localparam int PW = W + 19;

	logic [bpe_pkg::RAD_W-1:0] radius_q;
	logic [COORD_BITS-1:0]     x_q, y_q;
	logic [bpe_pkg::T_W-1:0]   t_q;

	logic [COORD_BITS-1:0] px_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] py_mem [MAX_POINTS];
	logic [W-1:0]          wx_mem [MAX_POINTS];
	logic [W-1:0]          wy_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] px_rd_q, py_rd_q;
	logic [W-1:0]          wx_rd_q, wy_rd_q;

	logic          vld_s1, first_s1, src_s1;
	logic [AW-1:0] waddr_s1;
	logic [W-1:0]  prev_x_q, prev_y_q;
	logic          vld_s2;
	logic [AW-1:0] waddr_s2;
	logic signed [PW-1:0] prod_x_s2, prod_y_s2;
	logic [W-1:0]  a_x_s2, a_y_s2;
	logic [W-1:0]  last_x_q, last_y_q;

	logic [COORD_BITS-1:0] dist_x, dist_y;
	logic [W-1:0]          bx, by, nx, ny;
	logic signed [W:0]     dfx, dfy;
	logic signed [17:0]    ts;

	// Hit radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bpe_pkg::HIT_RADIUS_RST;
		end else if (cfg_we) begin
			radius_q <= cfg_data;
		end
	end

	// Capture operands, saturate t at one
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			x_q <= COORD_BITS'(item.x_in);
			y_q <= COORD_BITS'(item.y_in);
			t_q <= (item.t_in > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : item.t_in;
		end
	end

	// Point table
	always_ff @(posedge clk) begin
		if (cmd.pt_we) begin
			px_mem[cmd.pt_waddr[AW-1:0]] <= cmd.pt_wsel ? px_rd_q : x_q;
			py_mem[cmd.pt_waddr[AW-1:0]] <= cmd.pt_wsel ? py_rd_q : y_q;
		end
		if (cmd.rd_en) begin
			px_rd_q <= px_mem[cmd.rd_addr[AW-1:0]];
			py_rd_q <= py_mem[cmd.rd_addr[AW-1:0]];
		end
	end

	// Interpolation scratch
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			wx_mem[waddr_s2] <= nx;
			wy_mem[waddr_s2] <= ny;
		end
		if (cmd.rd_en) begin
			wx_rd_q <= wx_mem[cmd.rd_addr[AW-1:0]];
			wy_rd_q <= wy_mem[cmd.rd_addr[AW-1:0]];
		end
	end

	// Per-axis distance test for find
	always_comb begin
		dist_x = (x_q >= px_rd_q) ? (x_q - px_rd_q) : (px_rd_q - x_q);
		dist_y = (y_q >= py_rd_q) ? (y_q - py_rd_q) : (py_rd_q - y_q);
	end

	// Stage 1: pick source, form t * (b - a)
	always_comb begin
		bx  = src_s1 ? {px_rd_q, {FRAC_BITS{1'b0}}} : wx_rd_q;
		by  = src_s1 ? {py_rd_q, {FRAC_BITS{1'b0}}} : wy_rd_q;
		dfx = $signed({1'b0, bx}) - $signed({1'b0, prev_x_q});
		dfy = $signed({1'b0, by}) - $signed({1'b0, prev_y_q});
		ts  = $signed({1'b0, t_q});
	end

	// Stage 2: a + floor(t * (b - a) / one)
	always_comb begin
		nx = a_x_s2 + W'(prod_x_s2 >>> bpe_pkg::T_BITS);
		ny = a_y_s2 + W'(prod_y_s2 >>> bpe_pkg::T_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.ev_vld;
			vld_s2 <= vld_s1 && !first_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.ev_first;
		src_s1    <= cmd.ev_src_pts;
		waddr_s1  <= cmd.ev_waddr[AW-1:0];
		if (vld_s1) begin
			prev_x_q <= bx;
			prev_y_q <= by;
		end
		prod_x_s2 <= ts * dfx;
		prod_y_s2 <= ts * dfy;
		a_x_s2    <= prev_x_q;
		a_y_s2    <= prev_y_q;
		waddr_s2  <= waddr_s1;
		if (vld_s2) begin
			last_x_q <= nx;
			last_y_q <= ny;
		end
	end

	assign st.hit   = (dist_x <= COORD_BITS'(radius_q)) && (dist_y <= COORD_BITS'(radius_q));
	assign st.res_x = bpe_pkg::PIX_W'(last_x_q >> FRAC_BITS);
	assign st.res_y = bpe_pkg::PIX_W'(last_y_q >> FRAC_BITS);

endmodule

[design/bpe_ctrl.sv]
module bpe_ctrl #(
	parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bpe_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output bpe_pkg::out_item_t  result,
	output bpe_pkg::cmd_t       cmd,
	input  bpe_pkg::dp_stat_t   st
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

	bpe_pkg::state_t  state_q, state_d;
	bpe_pkg::op_t     op_q;
	bpe_pkg::status_t stat_q, stat_d;
	logic [bpe_pkg::ADDR_W-1:0] idx_q, ires_q, ires_d;
	logic [CW-1:0] count_q, count_d, i_q, i_d, lvl_q, lvl_d;
	logic          drain_q, drain_d, src_q, src_d, evok_q, evok_d;
	logic          res_valid_q;
	bpe_pkg::out_item_t res_q;
	logic          load_res, accept, idx_bad;
	logic [CW:0]   i_p2;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != bpe_pkg::S_IDLE);
	assign load_res   = (state_q == bpe_pkg::S_DONE) && (!res_valid_q || !result_stall);
	assign idx_bad    = ({1'b0, idx_q} >= bpe_pkg::COUNT_W'(count_q));
	assign i_p2       = {1'b0, i_q} + (CW + 1)'(2);

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpe_pkg::S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			lvl_q   <= '0;
			drain_q <= 1'b0;
			src_q   <= 1'b0;
			evok_q  <= 1'b0;
			stat_q  <= bpe_pkg::ST_OK;
			ires_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q     <= i_d;
			lvl_q   <= lvl_d;
			drain_q <= drain_d;
			src_q   <= src_d;
			evok_q  <= evok_d;
			stat_q  <= stat_d;
			ires_q  <= ires_d;
		end
	end

	// Latch operation and index on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bpe_pkg::op_t'(item.operation);
			idx_q <= item.index_in;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		i_d     = i_q;
		lvl_d   = lvl_q;
		drain_d = drain_q;
		src_d   = src_q;
		evok_d  = evok_q;
		stat_d  = stat_q;
		ires_d  = ires_q;
		cmd     = '0;
		cmd.cap = accept;

		unique case (state_q)
			bpe_pkg::S_IDLE: begin
				if (accept) begin
					state_d = bpe_pkg::S_EXEC;
					stat_d  = bpe_pkg::ST_OK;
					ires_d  = '0;
					evok_d  = 1'b0;
				end
			end
			bpe_pkg::S_EXEC: begin
				state_d = bpe_pkg::S_DONE;
				unique case (op_q)
					bpe_pkg::OP_APPEND: begin
						if (count_q >= MAXC) begin
							stat_d = bpe_pkg::ST_FULL;
						end else begin
							cmd.pt_we    = 1'b1;
							cmd.pt_waddr = bpe_pkg::ADDR_W'(count_q);
							count_d      = count_q + 1'b1;
						end
					end
					bpe_pkg::OP_MOVE: begin
						if (idx_bad) begin
							stat_d = bpe_pkg::ST_BAD_INDEX;
						end else begin
							cmd.pt_we    = 1'b1;
							cmd.pt_waddr = idx_q;
						end
					end
					bpe_pkg::OP_DELETE: begin
						if (idx_bad) begin
							stat_d = bpe_pkg::ST_BAD_INDEX;
						end else if ({1'b0, idx_q} + 7'd1 < bpe_pkg::COUNT_W'(count_q)) begin
							i_d     = CW'(idx_q);
							state_d = bpe_pkg::S_DEL_RD;
						end else begin
							count_d = count_q - 1'b1;
						end
					end
					bpe_pkg::OP_REM_LAST: begin
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
						end
					end
					bpe_pkg::OP_CLEAR: begin
						count_d = '0;
					end
					bpe_pkg::OP_FIND: begin
						if (count_q == '0) begin
							stat_d = bpe_pkg::ST_NOT_FOUND;
						end else begin
							i_d     = '0;
							state_d = bpe_pkg::S_FIND_RD;
						end
					end
					bpe_pkg::OP_EVAL: begin
						if (count_q < CW'(2)) begin
							stat_d = bpe_pkg::ST_TOO_FEW;
						end else begin
							lvl_d   = count_q - 1'b1;
							i_d     = '0;
							src_d   = 1'b1;
							state_d = bpe_pkg::S_EV_RD;
						end
					end
					bpe_pkg::OP_NOP: begin
					end
					default: begin
					end
				endcase
			end
			// Shift one point down per pass
			bpe_pkg::S_DEL_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = bpe_pkg::ADDR_W'(i_q + 1'b1);
				state_d     = bpe_pkg::S_DEL_WR;
			end
			bpe_pkg::S_DEL_WR: begin
				cmd.pt_we    = 1'b1;
				cmd.pt_wsel  = 1'b1;
				cmd.pt_waddr = bpe_pkg::ADDR_W'(i_q);
				i_d          = i_q + 1'b1;
				if (i_p2 < {1'b0, count_q}) begin
					state_d = bpe_pkg::S_DEL_RD;
				end else begin
					count_d = count_q - 1'b1;
					state_d = bpe_pkg::S_DONE;
				end
			end
			// Scan points in order, stop at first hit
			bpe_pkg::S_FIND_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = bpe_pkg::ADDR_W'(i_q);
				state_d     = bpe_pkg::S_FIND_CMP;
			end
			bpe_pkg::S_FIND_CMP: begin
				if (st.hit) begin
					ires_d  = bpe_pkg::ADDR_W'(i_q);
					state_d = bpe_pkg::S_DONE;
				end else if ({1'b0, i_q} + (CW + 1)'(1) < {1'b0, count_q}) begin
					i_d     = i_q + 1'b1;
					state_d = bpe_pkg::S_FIND_RD;
				end else begin
					stat_d  = bpe_pkg::ST_NOT_FOUND;
					state_d = bpe_pkg::S_DONE;
				end
			end
			// Stream one level into the interpolator
			bpe_pkg::S_EV_RD: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_addr    = bpe_pkg::ADDR_W'(i_q);
				cmd.ev_vld     = 1'b1;
				cmd.ev_first   = (i_q == '0);
				cmd.ev_src_pts = src_q;
				cmd.ev_waddr   = bpe_pkg::ADDR_W'(i_q - 1'b1);
				if (i_q == lvl_q) begin
					i_d     = '0;
					drain_d = 1'b0;
					state_d = bpe_pkg::S_EV_DRAIN;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			// Let the last write of the level land
			bpe_pkg::S_EV_DRAIN: begin
				if (!drain_q) begin
					drain_d = 1'b1;
				end else if (lvl_q == CW'(1)) begin
					evok_d  = 1'b1;
					state_d = bpe_pkg::S_DONE;
				end else begin
					lvl_d   = lvl_q - 1'b1;
					src_d   = 1'b0;
					state_d = bpe_pkg::S_EV_RD;
				end
			end
			bpe_pkg::S_DONE: begin
				if (load_res) begin
					state_d = bpe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpe_pkg::S_IDLE;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.status    <= stat_q;
			res_q.x_out     <= evok_q ? st.res_x : '0;
			res_q.y_out     <= evok_q ? st.res_y : '0;
			res_q.index_out <= ires_q;
			res_q.count_out <= bpe_pkg::COUNT_W'(count_q);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Table never overfills
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC)
		else $error("point count above table size");

	// Count moves only on execute or the last delete shift
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state_q) == bpe_pkg::S_EXEC || $past(state_q) == bpe_pkg::S_DEL_WR))
		else $error("point count changed outside an update");

	// Level streaming stays within the active level
	a_ev_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpe_pkg::S_EV_RD) |-> (lvl_q != '0 && i_q <= lvl_q))
		else $error("evaluate read beyond level");

	// Successful evaluate needs at least two points
	a_ev_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpe_pkg::S_DONE && evok_q) |-> (count_q >= CW'(2)))
		else $error("evaluate finished with too few points");

	// A transfer starts execution next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == bpe_pkg::S_EXEC))
		else $error("accepted item not executed");

endmodule

[design/bezier_point_evaluator.sv]
// Channel  | handshake                | payload
// ---------+--------------------------+---------------------------------
// item     | item_valid / item_stall  | item   (in_item_t)
// result   | result_valid/result_stall| result (out_item_t)
// cfg      | cfg_valid / cfg_ready    | cfg_data (hit radius)
//
// Append, move, remove last, clear and no-op finish in the execute state and go to the result register.
// Delete shifts each later point down with a read and a write; find reads and compares each point scanned.
// Evaluate with n points runs levels L = n-1 down to 1, each streamed through
// the single scratch read port and the two-stage interpolator.
// Reset clears the point count and sets the hit radius to 2; no clearing pass.
// Input stalls until the result loads; a stalled result holds the next one at its end.
module bezier_point_evaluator #(
	parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  bpe_pkg::in_item_t         item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output bpe_pkg::out_item_t        result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bpe_pkg::RAD_W-1:0] cfg_data
);

	bpe_pkg::cmd_t     cmd;
	bpe_pkg::dp_stat_t st;

	// Register write always completes
	assign cfg_ready = 1'b1;

	bpe_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cmd         (cmd),
		.st          (st)
	);

	bpe_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.item    (item),
		.cmd     (cmd),
		.st      (st)
	);

endmodule
